### src/trimming_queue_phantom_ecn_defines.svh
// Assertion macros for the trimming queue block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TRIMMING_QUEUE_PHANTOM_ECN_DEFINES_SVH
`define TRIMMING_QUEUE_PHANTOM_ECN_DEFINES_SVH

// Check a condition on every clock edge out of reset
`define TQPE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tqpe: invariant violated");

// Check that a trigger implies a consequence in the same cycle
`define TQPE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tqpe: implication violated");

`endif

### src/tqpe_pkg.sv
// Shared constants, types and codes of the trimming queue block.
// No dependencies; the interfaces, top level, front end, back end and testbench import it.
package tqpe_pkg;

    // Storage and packet constants
    localparam int LOW_DEPTH         = 64;
    localparam int HIGH_DEPTH        = 256;
    localparam int HEADER_BYTES      = 64;
    localparam int DRAIN_BYTES       = 4160;
    localparam int HIGH_LIMIT_FACTOR = 200;

    localparam int LOW_AW  = $clog2(LOW_DEPTH);
    localparam int LOW_CW  = $clog2(LOW_DEPTH + 1);
    localparam int HIGH_AW = $clog2(HIGH_DEPTH);
    localparam int HIGH_CW = $clog2(HIGH_DEPTH + 1);

    // Field widths
    localparam int ACT_W      = 2;
    localparam int TAG_W      = 16;
    localparam int BYTES_W    = 14;
    localparam int KIND_W     = 2;
    localparam int RND_W      = 31;
    localparam int EV_W       = 3;
    localparam int MAXB_W     = 24;
    localparam int PHB_W      = 24;
    localparam int MARK_W     = 25;
    localparam int WGT_W      = 8;
    localparam int RR_W       = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // State widths
    localparam int LBC_W   = MAXB_W + 1;
    localparam int PH_W    = PHB_W + 1;
    localparam int LIMIT_W = MAXB_W + $clog2(HIGH_LIMIT_FACTOR + 1);
    localparam int HBC_W   = LIMIT_W + 1;
    localparam int PROD_W  = RND_W + 1 + MARK_W;

    // Divide by 100 through a reciprocal multiply, exact over PHB_W bits
    localparam int      PH_DIV_SHIFT = 38;
    localparam longint  PH_DIV_MULT  = ((64'd1 << PH_DIV_SHIFT) + 64'd99) / 64'd100;
    localparam int      PH_MULT_W    = 32;

    // Register reset values
    localparam logic [MAXB_W-1:0] MAX_BYTES_RST   = MAXB_W'(65536);
    localparam logic [MARK_W-1:0] ECN_MARK_RST    = MARK_W'(33554431);
    localparam logic [WGT_W-1:0]  WEIGHT_HIGH_RST = WGT_W'(100);
    localparam logic [WGT_W-1:0]  WEIGHT_LOW_RST  = WGT_W'(1);

    typedef enum logic [1:0] {
        OP_ARRIVE  = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [EV_W-1:0] {
        EV_QLOW   = 3'd0,
        EV_QHIGH  = 3'd1,
        EV_DEPART = 3'd2,
        EV_BOUNCE = 3'd3,
        EV_DROP   = 3'd4,
        EV_EMPTY  = 3'd5
    } ev_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BYTES      = 3'd0,
        CFG_DROP_WHEN_FULL = 3'd1,
        CFG_USE_PHANTOM    = 3'd2,
        CFG_PHANTOM_BYTES  = 3'd3,
        CFG_ECN_LOW_MARK   = 3'd4,
        CFG_ECN_HIGH_MARK  = 3'd5,
        CFG_WEIGHT_HIGH    = 3'd6,
        CFG_WEIGHT_LOW     = 3'd7
    } cfg_idx_t;

    // Stored descriptor; flag is bounce_ok in the low queue, trimmed in the high
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
        logic [KIND_W-1:0]  kind;
        logic               flag;
    } desc_t;

    typedef struct packed {
        op_t                op;
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] pkt_bytes;
        logic               header_only;
        logic [KIND_W-1:0]  pkt_kind;
        logic               bounce_ok;
        logic               trim_coin;
        logic [RND_W-1:0]   ecn_random;
    } item_t;

    typedef struct packed {
        ev_t                event_res;
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
        logic [KIND_W-1:0]  kind;
        logic               trimmed;
        logic               ecn_mark;
        logic               from_high;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [MAXB_W-1:0]  max_bytes;
        logic               drop_when_full;
        logic               use_phantom;
        logic [PHB_W-1:0]   phantom_bytes;
        logic [MARK_W-1:0]  ecn_low_mark;
        logic [MARK_W-1:0]  ecn_high_mark;
        logic [WGT_W-1:0]   weight_high;
        logic [WGT_W-1:0]   weight_low;
        logic [LIMIT_W-1:0] high_limit;
        logic [PHB_W-1:0]   ph_lo;
        logic [PHB_W-1:0]   ph_hi;
    } cfg_t;

    typedef struct packed {
        logic [LOW_CW-1:0]  low_count;
        logic [HIGH_CW-1:0] high_count;
    } stat_t;

endpackage

### src/tqpe_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on tqpe_pkg for field widths.
interface tqpe_in_if import tqpe_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] pkt_bytes;
    logic               header_only;
    logic [KIND_W-1:0]  pkt_kind;
    logic               bounce_ok;
    logic               trim_coin;
    logic [RND_W-1:0]   ecn_random;

    modport source (output valid, action, tag, pkt_bytes, header_only, pkt_kind,
                    bounce_ok, trim_coin, ecn_random, input ready);
    modport sink   (input valid, action, tag, pkt_bytes, header_only, pkt_kind,
                    bounce_ok, trim_coin, ecn_random, output ready);
endinterface

interface tqpe_out_if import tqpe_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [EV_W-1:0]    event_res;
    logic [TAG_W-1:0]   out_tag;
    logic [BYTES_W-1:0] out_bytes;
    logic [KIND_W-1:0]  out_kind;
    logic               trimmed;
    logic               ecn_mark;
    logic               from_high;
    logic               last;

    modport source (output valid, event_res, out_tag, out_bytes, out_kind, trimmed,
                    ecn_mark, from_high, last, input ready);
    modport sink   (input valid, event_res, out_tag, out_bytes, out_kind, trimmed,
                    ecn_mark, from_high, last, output ready);
endinterface

### src/trimming_queue_phantom_ecn.sv
// Top level of the packet trimming queue with phantom-queue ECN marking.
// Depends on tqpe_pkg, tqpe_if, tqpe_front, tqpe_back and the defines header.
`include "trimming_queue_phantom_ecn_defines.svh"

// Packet descriptors enter on in_ch, pass a two-item input queue and are run by
// a sequencer one at a time; results leave on out_ch through one output register,
// so the input side keeps accepting while a result waits. The back end sequencer
// handles an arrival, tick or unused action in its idle state; an arrival that
// evicts the newest low entry steps through a registered memory read, then the
// eviction result, then the arrival result; a dequeue steps through head read,
// byte count update, ECN thresholds, ECN multiply and result. Each result also
// waits for out_ch to drain its register. Configuration writes go straight into
// their registers; the high byte limit and phantom_bytes / 100 are registered
// from them. Descriptor stores need no clearing after reset.
module trimming_queue_phantom_ecn import tqpe_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    tqpe_in_if.sink               in_ch,
    tqpe_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MAXB_W-1:0]  max_bytes_reg;
    logic               drop_when_full_reg;
    logic               use_phantom_reg;
    logic [PHB_W-1:0]   phantom_bytes_reg;
    logic [MARK_W-1:0]  ecn_low_mark_reg;
    logic [MARK_W-1:0]  ecn_high_mark_reg;
    logic [WGT_W-1:0]   weight_high_reg;
    logic [WGT_W-1:0]   weight_low_reg;
    logic [LIMIT_W-1:0] high_limit_reg, high_limit_next;
    logic [PHB_W-1:0]   ph_q_reg, ph_q_next;
    logic [PHB_W+PH_MULT_W-1:0] ph_prod;
    logic [PHB_W+6:0]   ph_hi_wide, ph_lo_wide;
    cfg_t               cfg;
    stat_t              stat;
    logic               item_valid;
    item_t              item;
    logic               item_pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg      <= MAX_BYTES_RST;
            drop_when_full_reg <= 1'b0;
            use_phantom_reg    <= 1'b0;
            phantom_bytes_reg  <= '0;
            ecn_low_mark_reg   <= ECN_MARK_RST;
            ecn_high_mark_reg  <= ECN_MARK_RST;
            weight_high_reg    <= WEIGHT_HIGH_RST;
            weight_low_reg     <= WEIGHT_LOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_BYTES:      max_bytes_reg      <= cfg_data[MAXB_W-1:0];
                CFG_DROP_WHEN_FULL: drop_when_full_reg <= cfg_data[0];
                CFG_USE_PHANTOM:    use_phantom_reg    <= cfg_data[0];
                CFG_PHANTOM_BYTES:  phantom_bytes_reg  <= cfg_data[PHB_W-1:0];
                CFG_ECN_LOW_MARK:   ecn_low_mark_reg   <= cfg_data[MARK_W-1:0];
                CFG_ECN_HIGH_MARK:  ecn_high_mark_reg  <= cfg_data[MARK_W-1:0];
                CFG_WEIGHT_HIGH:    weight_high_reg    <= cfg_data[WGT_W-1:0];
                CFG_WEIGHT_LOW:     weight_low_reg     <= cfg_data[WGT_W-1:0];
                default:            max_bytes_reg      <= max_bytes_reg;
            endcase
        end
    end

    // Derive the high byte limit and phantom_bytes / 100
    always_comb
    begin
        high_limit_next = LIMIT_W'(max_bytes_reg * HIGH_LIMIT_FACTOR);
        ph_prod   = (PHB_W + PH_MULT_W)'(phantom_bytes_reg) *
                    (PHB_W + PH_MULT_W)'(PH_DIV_MULT[PH_MULT_W-1:0]);
        ph_q_next = PHB_W'(ph_prod >> PH_DIV_SHIFT);
        // Thresholds at 80 and 20 percent of the phantom capacity
        ph_hi_wide = ((PHB_W + 7)'(ph_q_reg) << 6) + ((PHB_W + 7)'(ph_q_reg) << 4);
        ph_lo_wide = ((PHB_W + 7)'(ph_q_reg) << 4) + ((PHB_W + 7)'(ph_q_reg) << 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_limit_reg <= LIMIT_W'(MAX_BYTES_RST * HIGH_LIMIT_FACTOR);
            ph_q_reg       <= '0;
        end
        else
        begin
            high_limit_reg <= high_limit_next;
            ph_q_reg       <= ph_q_next;
        end
    end

    always_comb
    begin
        cfg.max_bytes      = max_bytes_reg;
        cfg.drop_when_full = drop_when_full_reg;
        cfg.use_phantom    = use_phantom_reg;
        cfg.phantom_bytes  = phantom_bytes_reg;
        cfg.ecn_low_mark   = ecn_low_mark_reg;
        cfg.ecn_high_mark  = ecn_high_mark_reg;
        cfg.weight_high    = weight_high_reg;
        cfg.weight_low     = weight_low_reg;
        cfg.high_limit     = high_limit_reg;
        cfg.ph_lo          = ph_lo_wide[PHB_W-1:0];
        cfg.ph_hi          = ph_hi_wide[PHB_W-1:0];
    end

    tqpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    tqpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_ch     (out_ch),
        .stat       (stat)
    );

    // Occupancy never passes the descriptor store depth
    `TQPE_ASSERT_ALWAYS(a_low_count_bound, stat.low_count <= LOW_CW'(LOW_DEPTH))
    `TQPE_ASSERT_ALWAYS(a_high_count_bound, stat.high_count <= HIGH_CW'(HIGH_DEPTH))
    // An empty result carries no descriptor
    `TQPE_ASSERT_IMP(a_empty_zero, out_ch.valid && (out_ch.event_res == EV_EMPTY),
        (out_ch.out_tag == '0) && (out_ch.out_bytes == '0) && !out_ch.trimmed && out_ch.last)
    // Only departures carry ECN and queue origin
    `TQPE_ASSERT_IMP(a_depart_flags, out_ch.valid && (out_ch.event_res != EV_DEPART),
        !out_ch.ecn_mark && !out_ch.from_high)

endmodule

### src/tqpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tqpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/tqpe_front.sv
// Front end: accepts input items, decodes the action and queues them.
// Depends on tqpe_pkg and tqpe_in_if.
module tqpe_front import tqpe_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    tqpe_in_if.sink  in_ch,
    output logic     item_valid,
    output item_t    item,
    input  logic     item_pop
);

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    item_t              fq_reg [FQ_DEPTH];
    logic [FQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FQ_CW-1:0]   count_reg, count_next;
    logic               push;
    item_t              dec;

    assign in_ch.ready = (count_reg < FQ_CW'(FQ_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign item_valid  = (count_reg != '0);
    assign item        = fq_reg[rd_ptr_reg];

    // Classify the action
    always_comb
    begin
        dec.tag         = in_ch.tag;
        dec.pkt_bytes   = in_ch.pkt_bytes;
        dec.header_only = in_ch.header_only;
        dec.pkt_kind    = in_ch.pkt_kind;
        dec.bounce_ok   = in_ch.bounce_ok;
        dec.trim_coin   = in_ch.trim_coin;
        dec.ecn_random  = in_ch.ecn_random;
        unique case (in_ch.action)
            2'd0:    dec.op = OP_ARRIVE;
            2'd1:    dec.op = OP_DEQUEUE;
            2'd2:    dec.op = OP_TICK;
            default: dec.op = OP_NONE;
        endcase
    end

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop && item_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(item_pop && item_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && item_pop && item_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the decoded item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fq_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

### src/tqpe_back.sv
// Back end: sequencer that runs queued items against the two descriptor FIFOs,
// byte counts, phantom level and ECN logic. Depends on tqpe_pkg, tqpe_ram, tqpe_out_if.
module tqpe_back import tqpe_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    input  item_t      item,
    output logic       item_pop,
    tqpe_out_if.source out_ch,
    output stat_t      stat
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_EV_READ = 7'b0000010,
        ST_EV_POST = 7'b0000100,
        ST_DQ_READ = 7'b0001000,
        ST_DQ_THR  = 7'b0010000,
        ST_DQ_MUL  = 7'b0100000,
        ST_DQ_OUT  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [LOW_AW-1:0]   low_head_reg, low_head_next;
    logic [LOW_CW-1:0]   low_count_reg, low_count_next;
    logic [HIGH_AW-1:0]  high_head_reg, high_head_next;
    logic [HIGH_CW-1:0]  high_count_reg, high_count_next;
    logic [LBC_W-1:0]    lbc_reg, lbc_next;
    logic [HBC_W-1:0]    hbc_reg, hbc_next;
    logic [PH_W-1:0]     ph_reg, ph_next;
    logic [RR_W-1:0]     rr_reg, rr_next;
    logic                serve_high_reg, serve_high_next;
    logic                cmp_hi_reg, cmp_hi_next;
    logic                cmp_lo_reg, cmp_lo_next;
    logic [MARK_W-1:0]   dn_reg, dn_next;
    logic [MARK_W-1:0]   dd_reg, dd_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [PROD_W-1:0]   num_reg, num_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    // Memory ports
    logic                low_we, low_re, high_we, high_re;
    logic [LOW_AW-1:0]   low_waddr, low_raddr;
    logic [HIGH_AW-1:0]  high_waddr, high_raddr;
    desc_t               low_wdata, high_wdata;
    logic [$bits(desc_t)-1:0] low_rraw, high_rraw;
    desc_t               low_rdata, high_rdata;

    // Helpers
    logic                out_free;
    logic                emit;
    res_t                res;
    item_t               arr;
    logic [LOW_AW:0]     low_ext, low_tail_ext, low_new_ext;
    logic [LOW_AW-1:0]   low_tail, low_newest, low_head_inc;
    logic [HIGH_AW:0]    high_ext, high_tail_ext;
    logic [HIGH_AW-1:0]  high_tail, high_head_inc;
    logic [LBC_W:0]      lbc_sum;
    logic                fits;
    logic                low_full;
    logic                push_low;
    logic [PH_W:0]       ph_sum;
    desc_t               th_desc;
    logic                th_bounce;
    logic                th_use;
    logic [HBC_W-1:0]    th_sum;
    ev_t                 th_event;
    desc_t               dq_desc;
    logic [RR_W-1:0]     rr_inc, rr_wrap, wsum;
    logic [MARK_W-1:0]   level, lo_thr, hi_thr;
    logic [RND_W:0]      rnd_p1;
    logic                ecn_on;

    tqpe_ram #(.WIDTH($bits(desc_t)), .DEPTH(LOW_DEPTH)) u_low_ram (
        .clk   (clk),
        .we    (low_we),
        .waddr (low_waddr),
        .wdata (low_wdata),
        .re    (low_re),
        .raddr (low_raddr),
        .rdata (low_rraw)
    );

    tqpe_ram #(.WIDTH($bits(desc_t)), .DEPTH(HIGH_DEPTH)) u_high_ram (
        .clk   (clk),
        .we    (high_we),
        .waddr (high_waddr),
        .wdata (high_wdata),
        .re    (high_re),
        .raddr (high_raddr),
        .rdata (high_rraw)
    );

    assign low_rdata  = desc_t'(low_rraw);
    assign high_rdata = desc_t'(high_rraw);
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign arr        = (state_reg == ST_IDLE) ? item : item_reg;
    assign stat.low_count  = low_count_reg;
    assign stat.high_count = high_count_reg;

    // Wrap FIFO positions
    always_comb
    begin
        low_ext      = (LOW_AW + 1)'(low_head_reg) + (LOW_AW + 1)'(low_count_reg);
        low_tail_ext = (low_ext >= (LOW_AW + 1)'(LOW_DEPTH)) ?
                       low_ext - (LOW_AW + 1)'(LOW_DEPTH) : low_ext;
        low_tail     = low_tail_ext[LOW_AW-1:0];
        low_new_ext  = low_ext - 1'b1;
        if (low_new_ext >= (LOW_AW + 1)'(LOW_DEPTH))
        begin
            low_new_ext = low_new_ext - (LOW_AW + 1)'(LOW_DEPTH);
        end
        low_newest   = low_new_ext[LOW_AW-1:0];
        low_head_inc = (low_head_reg == LOW_AW'(LOW_DEPTH - 1)) ? '0 : low_head_reg + 1'b1;

        high_ext      = (HIGH_AW + 1)'(high_head_reg) + (HIGH_AW + 1)'(high_count_reg);
        high_tail_ext = (high_ext >= (HIGH_AW + 1)'(HIGH_DEPTH)) ?
                        high_ext - (HIGH_AW + 1)'(HIGH_DEPTH) : high_ext;
        high_tail     = high_tail_ext[HIGH_AW-1:0];
        high_head_inc = (high_head_reg == HIGH_AW'(HIGH_DEPTH - 1)) ? '0 : high_head_reg + 1'b1;
    end

    // Check fit in the low queue and room for a push
    always_comb
    begin
        lbc_sum  = (LBC_W + 1)'(lbc_reg) + (LBC_W + 1)'(arr.pkt_bytes);
        fits     = (lbc_sum <= (LBC_W + 1)'(cfg.max_bytes));
        low_full = (low_count_reg >= LOW_CW'(LOW_DEPTH));
    end

    // Classify a header-sized descriptor against the high limit and the high store room
    always_comb
    begin
        th_sum = hbc_reg + HBC_W'(th_desc.bytes);
        if (th_sum > HBC_W'(cfg.high_limit))
        begin
            th_event = th_bounce ? EV_BOUNCE : EV_DROP;
        end
        else if (high_count_reg >= HIGH_CW'(HIGH_DEPTH))
        begin
            th_event = EV_DROP;
        end
        else
        begin
            th_event = EV_QHIGH;
        end
    end

    // Round robin step and ECN operands
    always_comb
    begin
        rr_inc  = rr_reg + 1'b1;
        wsum    = RR_W'(cfg.weight_high) + RR_W'(cfg.weight_low);
        rr_wrap = (rr_inc >= wsum) ? '0 : rr_inc;
        dq_desc = serve_high_reg ? high_rdata : low_rdata;
        level   = cfg.use_phantom ? ph_reg : lbc_reg;
        lo_thr  = cfg.use_phantom ? MARK_W'(cfg.ph_lo) : cfg.ecn_low_mark;
        hi_thr  = cfg.use_phantom ? MARK_W'(cfg.ph_hi) : cfg.ecn_high_mark;
        rnd_p1  = (RND_W + 1)'(item_reg.ecn_random) + 1'b1;
        ecn_on  = !serve_high_reg || (dq_desc.kind == '0);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        low_head_next   = low_head_reg;
        low_count_next  = low_count_reg;
        high_head_next  = high_head_reg;
        high_count_next = high_count_reg;
        lbc_next        = lbc_reg;
        hbc_next        = hbc_reg;
        ph_next         = ph_reg;
        rr_next         = rr_reg;
        serve_high_next = serve_high_reg;
        cmp_hi_next     = cmp_hi_reg;
        cmp_lo_next     = cmp_lo_reg;
        dn_next         = dn_reg;
        dd_next         = dd_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        item_pop        = 1'b0;
        emit            = 1'b0;
        res             = '0;
        th_desc         = '0;
        th_bounce       = 1'b0;
        th_use          = 1'b0;
        push_low        = 1'b0;
        low_re          = 1'b0;
        low_raddr       = low_head_reg;
        high_re         = 1'b0;
        high_raddr      = high_head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && out_free)
                begin
                    item_pop  = 1'b1;
                    item_next = item;
                    unique case (item.op)
                        OP_ARRIVE:
                        begin
                            res.tag  = item.tag;
                            res.kind = item.pkt_kind;
                            res.bytes = item.pkt_bytes;
                            res.last = 1'b1;
                            if (item.header_only)
                            begin
                                // Header-only packets go high untrimmed
                                th_use        = 1'b1;
                                th_desc.tag   = item.tag;
                                th_desc.bytes = item.pkt_bytes;
                                th_desc.kind  = item.pkt_kind;
                                th_desc.flag  = 1'b0;
                                th_bounce     = item.bounce_ok;
                                emit          = 1'b1;
                                res.event_res = th_event;
                            end
                            else if (!fits && cfg.drop_when_full)
                            begin
                                emit          = 1'b1;
                                res.event_res = EV_DROP;
                            end
                            else if (!fits && item.trim_coin && (low_count_reg != '0))
                            begin
                                // Fetch the newest low entry for eviction
                                low_re     = 1'b1;
                                low_raddr  = low_newest;
                                state_next = ST_EV_READ;
                            end
                            else if (fits)
                            begin
                                emit          = 1'b1;
                                push_low      = !low_full;
                                res.event_res = low_full ? EV_DROP : EV_QLOW;
                            end
                            else
                            begin
                                // Trim the arrival and send it high
                                th_use        = 1'b1;
                                th_desc.tag   = item.tag;
                                th_desc.bytes = BYTES_W'(HEADER_BYTES);
                                th_desc.kind  = item.pkt_kind;
                                th_desc.flag  = 1'b1;
                                th_bounce     = item.bounce_ok;
                                emit          = 1'b1;
                                res.event_res = th_event;
                                res.bytes     = BYTES_W'(HEADER_BYTES);
                                res.trimmed   = 1'b1;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if ((high_count_reg == '0) && (low_count_reg == '0))
                            begin
                                emit          = 1'b1;
                                res.event_res = EV_EMPTY;
                                res.last      = 1'b1;
                            end
                            else
                            begin
                                if ((high_count_reg != '0) && (low_count_reg != '0))
                                begin
                                    rr_next         = rr_wrap;
                                    serve_high_next = (rr_wrap < RR_W'(cfg.weight_high));
                                end
                                else
                                begin
                                    serve_high_next = (high_count_reg != '0);
                                end
                                // Read the head and pop it
                                if (serve_high_next)
                                begin
                                    high_re         = 1'b1;
                                    high_head_next  = high_head_inc;
                                    high_count_next = high_count_reg - 1'b1;
                                end
                                else
                                begin
                                    low_re         = 1'b1;
                                    low_head_next  = low_head_inc;
                                    low_count_next = low_count_reg - 1'b1;
                                end
                                state_next = ST_DQ_READ;
                            end
                        end
                        OP_TICK:
                        begin
                            if (cfg.use_phantom)
                            begin
                                ph_next = (ph_reg > PH_W'(DRAIN_BYTES)) ?
                                          ph_reg - PH_W'(DRAIN_BYTES) : '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EV_READ:
            begin
                if (out_free)
                begin
                    // Evict: drop the newest low entry and trim it toward high
                    low_count_next = low_count_reg - 1'b1;
                    lbc_next = (lbc_reg > LBC_W'(low_rdata.bytes)) ?
                               lbc_reg - LBC_W'(low_rdata.bytes) : '0;
                    ph_next  = (ph_reg > PH_W'(low_rdata.bytes)) ?
                               ph_reg - PH_W'(low_rdata.bytes) : '0;
                    th_use        = 1'b1;
                    th_desc.tag   = low_rdata.tag;
                    th_desc.bytes = BYTES_W'(HEADER_BYTES);
                    th_desc.kind  = low_rdata.kind;
                    th_desc.flag  = 1'b1;
                    th_bounce     = low_rdata.flag;
                    emit          = 1'b1;
                    res.event_res = th_event;
                    res.tag       = low_rdata.tag;
                    res.bytes     = BYTES_W'(HEADER_BYTES);
                    res.kind      = low_rdata.kind;
                    res.trimmed   = 1'b1;
                    state_next    = ST_EV_POST;
                end
            end
            ST_EV_POST:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res.tag    = item_reg.tag;
                    res.kind   = item_reg.pkt_kind;
                    res.last   = 1'b1;
                    state_next = ST_IDLE;
                    if (fits)
                    begin
                        push_low      = !low_full;
                        res.event_res = low_full ? EV_DROP : EV_QLOW;
                        res.bytes     = item_reg.pkt_bytes;
                    end
                    else
                    begin
                        // Still too big after one eviction: trim the arrival
                        th_use        = 1'b1;
                        th_desc.tag   = item_reg.tag;
                        th_desc.bytes = BYTES_W'(HEADER_BYTES);
                        th_desc.kind  = item_reg.pkt_kind;
                        th_desc.flag  = 1'b1;
                        th_bounce     = item_reg.bounce_ok;
                        res.event_res = th_event;
                        res.bytes     = BYTES_W'(HEADER_BYTES);
                        res.trimmed   = 1'b1;
                    end
                end
            end
            ST_DQ_READ:
            begin
                // Take the departing bytes off the serving queue
                if (serve_high_reg)
                begin
                    hbc_next = (hbc_reg > HBC_W'(high_rdata.bytes)) ?
                               hbc_reg - HBC_W'(high_rdata.bytes) : '0;
                end
                else
                begin
                    lbc_next = (lbc_reg > LBC_W'(low_rdata.bytes)) ?
                               lbc_reg - LBC_W'(low_rdata.bytes) : '0;
                end
                state_next = ST_DQ_THR;
            end
            ST_DQ_THR:
            begin
                cmp_hi_next = (level > hi_thr);
                cmp_lo_next = (level > lo_thr);
                dn_next     = level - lo_thr;
                dd_next     = hi_thr - lo_thr;
                state_next  = ST_DQ_MUL;
            end
            ST_DQ_MUL:
            begin
                // Compare rnd < N/D as (rnd + 1) * D <= N
                prod_next  = PROD_W'(rnd_p1) * PROD_W'(dd_reg);
                num_next   = (PROD_W'(dn_reg) << RND_W) - PROD_W'(dn_reg);
                state_next = ST_DQ_OUT;
            end
            ST_DQ_OUT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    res.event_res = EV_DEPART;
                    res.tag       = dq_desc.tag;
                    res.bytes     = dq_desc.bytes;
                    res.kind      = dq_desc.kind;
                    res.trimmed   = serve_high_reg && dq_desc.flag;
                    res.ecn_mark  = ecn_on && (cmp_hi_reg || (cmp_lo_reg && (prod_reg <= num_reg)));
                    res.from_high = serve_high_reg;
                    res.last      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the output register
        if (emit)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end

        // Push into the high queue
        if (th_use && (th_event == EV_QHIGH))
        begin
            high_count_next = high_count_next + 1'b1;
            hbc_next        = hbc_reg + HBC_W'(th_desc.bytes);
        end

        // Push into the low queue and feed the phantom level
        ph_sum = (PH_W + 1)'(ph_reg) + (PH_W + 1)'(arr.pkt_bytes);
        if (push_low)
        begin
            low_count_next = low_count_reg + 1'b1;
            lbc_next       = LBC_W'(lbc_sum);
            ph_next        = (ph_sum > (PH_W + 1)'(cfg.phantom_bytes)) ?
                             PH_W'(cfg.phantom_bytes) : PH_W'(ph_sum);
        end
    end

    // Memory write ports
    always_comb
    begin
        low_we     = push_low;
        low_waddr  = low_tail;
        low_wdata.tag   = arr.tag;
        low_wdata.bytes = arr.pkt_bytes;
        low_wdata.kind  = arr.pkt_kind;
        low_wdata.flag  = arr.bounce_ok;
        high_we    = th_use && (th_event == EV_QHIGH);
        high_waddr = high_tail;
        high_wdata = th_desc;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.event_res = out_reg.event_res;
    assign out_ch.out_tag   = out_reg.tag;
    assign out_ch.out_bytes = out_reg.bytes;
    assign out_ch.out_kind  = out_reg.kind;
    assign out_ch.trimmed   = out_reg.trimmed;
    assign out_ch.ecn_mark  = out_reg.ecn_mark;
    assign out_ch.from_high = out_reg.from_high;
    assign out_ch.last      = out_reg.last;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_head_reg   <= '0;
            low_count_reg  <= '0;
            high_head_reg  <= '0;
            high_count_reg <= '0;
            lbc_reg        <= '0;
            hbc_reg        <= '0;
            ph_reg         <= '0;
            rr_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_head_reg   <= low_head_next;
            low_count_reg  <= low_count_next;
            high_head_reg  <= high_head_next;
            high_count_reg <= high_count_next;
            lbc_reg        <= lbc_next;
            hbc_reg        <= hbc_next;
            ph_reg         <= ph_next;
            rr_reg         <= rr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        serve_high_reg <= serve_high_next;
        cmp_hi_reg     <= cmp_hi_next;
        cmp_lo_reg     <= cmp_lo_next;
        dn_reg         <= dn_next;
        dd_reg         <= dd_next;
        prod_reg       <= prod_next;
        num_reg        <= num_next;
        out_reg        <= out_next;
    end

endmodule

### bench/trimming_queue_phantom_ecn_test.sv
// Self-checking testbench for the trimming queue with phantom-queue ECN marking.
// Depends on tqpe_pkg, tqpe_if and the trimming_queue_phantom_ecn top level.
module trimming_queue_phantom_ecn_test;
    import tqpe_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  RESET_CYC   = 9;
    localparam int  SETTLE_CYC  = 16;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  RAND_ITEMS  = 1850;

    typedef enum int {
        IDLE_NONE   = 0,
        IDLE_SEND   = 1,
        IDLE_RECV   = 2,
        IDLE_BOTH   = 3
    } idle_mode_t;

    typedef struct {
        item_t it;
        bit    has_exp;
        res_t  exp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tqpe_in_if  in_ch ();
    tqpe_out_if out_ch ();

    trimming_queue_phantom_ecn u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow configuration
    longint unsigned sh_max_bytes, sh_drop_full, sh_use_ph, sh_ph_bytes;
    longint unsigned sh_ecn_lo, sh_ecn_hi, sh_w_high, sh_w_low;

    // Shadow queue state
    desc_t           low_mem  [LOW_DEPTH];
    desc_t           high_mem [HIGH_DEPTH];
    int              low_hd, low_cnt, high_hd, high_cnt;
    longint unsigned low_bytes, high_bytes, ph_level, rr_cnt;

    res_t       pending_res[$];
    int         err_count;
    int         items_sent;
    int         results_seen;
    int         cycle_count;
    idle_mode_t idle_mode;
    dir_row_t   dir_rows[$];

    // Clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_res.size());
            $display("[trimming_queue_phantom_ecn] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        err_count++;
        $display("mismatch result %0d %s: got %0h expected %0h", results_seen, what, got,
                 want);
    endtask

    // Saturating subtract used by the byte counters
    function automatic longint unsigned sat_sub(input longint unsigned a,
                                                input longint unsigned b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic void push_result(input ev_t ev, input desc_t d, input bit trim,
                                        input bit mark, input bit fh);
        res_t r;
        r.event_res = ev;
        r.tag       = d.tag;
        r.bytes     = d.bytes;
        r.kind      = d.kind;
        r.trimmed   = trim;
        r.ecn_mark  = mark;
        r.from_high = fh;
        r.last      = 1'b0;
        pending_res.push_back(r);
    endfunction

    // RED marking decision from phantom level or low byte count
    function automatic bit ecn_verdict(input longint unsigned rnd);
        longint unsigned level, lo, hi, prob;
        if (sh_use_ph != 0)
        begin
            level = ph_level;
            hi    = sh_ph_bytes / 100 * 80;
            lo    = sh_ph_bytes / 100 * 20;
        end
        else
        begin
            level = low_bytes;
            hi    = sh_ecn_hi;
            lo    = sh_ecn_lo;
        end
        if (level > hi)
            return 1'b1;
        if (level > lo)
        begin
            prob = (64'h7FFF_FFFF * (level - lo)) / (hi - lo);
            return rnd < prob;
        end
        return 1'b0;
    endfunction

    // Place a header-sized descriptor in the high store
    function automatic ev_t place_high(input desc_t d, input bit trim, input bit bounce);
        int pos;
        if (high_bytes + d.bytes > longint'(HIGH_LIMIT_FACTOR) * sh_max_bytes)
            return bounce ? EV_BOUNCE : EV_DROP;
        if (high_cnt >= HIGH_DEPTH)
            return EV_DROP;
        pos = (high_hd + high_cnt) % HIGH_DEPTH;
        high_mem[pos]      = d;
        high_mem[pos].flag = trim;
        high_cnt++;
        high_bytes += d.bytes;
        return EV_QHIGH;
    endfunction

    // Work out the results of one accepted item and queue them
    function automatic void predict_queue(input item_t it);
        desc_t d, ev_d;
        bit    fits, trim, mark, serve_high;
        int    pos;
        d.tag   = it.tag;
        d.bytes = it.pkt_bytes;
        d.kind  = it.pkt_kind;
        d.flag  = it.bounce_ok;
        trim    = 1'b0;
        case (it.op)
            OP_ARRIVE:
            begin
                if (!it.header_only)
                begin
                    fits = low_bytes + d.bytes <= sh_max_bytes;
                    if (!fits && sh_drop_full != 0)
                    begin
                        push_result(EV_DROP, d, 1'b0, 1'b0, 1'b0);
                        pending_res[$].last = 1'b1;
                        return;
                    end
                    // Evict the newest low entry and move its header high
                    if (!fits && it.trim_coin && low_cnt > 0)
                    begin
                        pos  = (low_hd + low_cnt - 1) % LOW_DEPTH;
                        ev_d = low_mem[pos];
                        low_cnt--;
                        low_bytes  = sat_sub(low_bytes, ev_d.bytes);
                        ph_level   = sat_sub(ph_level, ev_d.bytes);
                        ev_d.bytes = BYTES_W'(HEADER_BYTES);
                        push_result(place_high(ev_d, 1'b1, ev_d.flag), ev_d, 1'b1, 1'b0,
                                    1'b0);
                        fits = low_bytes + d.bytes <= sh_max_bytes;
                    end
                    if (fits)
                    begin
                        if (low_cnt >= LOW_DEPTH)
                            push_result(EV_DROP, d, 1'b0, 1'b0, 1'b0);
                        else
                        begin
                            low_mem[(low_hd + low_cnt) % LOW_DEPTH] = d;
                            low_cnt++;
                            low_bytes += d.bytes;
                            ph_level  += d.bytes;
                            if (ph_level > sh_ph_bytes)
                                ph_level = sh_ph_bytes;
                            push_result(EV_QLOW, d, 1'b0, 1'b0, 1'b0);
                        end
                        pending_res[$].last = 1'b1;
                        return;
                    end
                    d.bytes = BYTES_W'(HEADER_BYTES);
                    trim    = 1'b1;
                end
                push_result(place_high(d, trim, it.bounce_ok), d, trim, 1'b0, 1'b0);
                pending_res[$].last = 1'b1;
            end
            OP_DEQUEUE:
            begin
                if (high_cnt == 0 && low_cnt == 0)
                begin
                    push_result(EV_EMPTY, '0, 1'b0, 1'b0, 1'b0);
                    pending_res[$].last = 1'b1;
                    return;
                end
                if (high_cnt > 0 && low_cnt > 0)
                begin
                    rr_cnt++;
                    if (rr_cnt >= sh_w_high + sh_w_low)
                        rr_cnt = 0;
                    serve_high = rr_cnt < sh_w_high;
                end
                else
                    serve_high = high_cnt > 0;
                if (serve_high)
                begin
                    d       = high_mem[high_hd];
                    high_hd = (high_hd + 1) % HIGH_DEPTH;
                    high_cnt--;
                    high_bytes = sat_sub(high_bytes, d.bytes);
                    mark = (d.kind == 0) ? ecn_verdict(it.ecn_random) : 1'b0;
                    push_result(EV_DEPART, d, d.flag, mark, 1'b1);
                end
                else
                begin
                    d      = low_mem[low_hd];
                    low_hd = (low_hd + 1) % LOW_DEPTH;
                    low_cnt--;
                    low_bytes = sat_sub(low_bytes, d.bytes);
                    mark = ecn_verdict(it.ecn_random);
                    push_result(EV_DEPART, d, 1'b0, mark, 1'b0);
                end
                pending_res[$].last = 1'b1;
            end
            OP_TICK:
            begin
                if (sh_use_ph != 0)
                    ph_level = sat_sub(ph_level, DRAIN_BYTES);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_res.size() == 0)
                report_mismatch("unexpected result, event", out_ch.event_res, 0);
            else
            begin
                want = pending_res.pop_front();
                if (out_ch.event_res !== want.event_res)
                    report_mismatch("event_res", out_ch.event_res, want.event_res);
                if (out_ch.out_tag !== want.tag)
                    report_mismatch("out_tag", out_ch.out_tag, want.tag);
                if (out_ch.out_bytes !== want.bytes)
                    report_mismatch("out_bytes", out_ch.out_bytes, want.bytes);
                if (out_ch.out_kind !== want.kind)
                    report_mismatch("out_kind", out_ch.out_kind, want.kind);
                if (out_ch.trimmed !== want.trimmed)
                    report_mismatch("trimmed", out_ch.trimmed, want.trimmed);
                if (out_ch.ecn_mark !== want.ecn_mark)
                    report_mismatch("ecn_mark", out_ch.ecn_mark, want.ecn_mark);
                if (out_ch.from_high !== want.from_high)
                    report_mismatch("from_high", out_ch.from_high, want.from_high);
                if (out_ch.last !== want.last)
                    report_mismatch("last", out_ch.last, want.last);
            end
            results_seen++;
        end
    end

    // Receiver stalls
    always @(posedge clk)
    begin
        case (idle_mode)
            IDLE_RECV: out_ch.ready <= ($urandom_range(99) >= 83);
            IDLE_BOTH: out_ch.ready <= ($urandom_range(99) >= 13);
            default:   out_ch.ready <= 1'b1;
        endcase
    end

    function automatic item_t make_item(input op_t op, input logic [TAG_W-1:0] tag,
                                        input int nbytes, input bit hdr, input int kind,
                                        input bit bounce, input bit coin,
                                        input logic [RND_W-1:0] rnd);
        item_t it;
        it.op          = op;
        it.tag         = tag;
        it.pkt_bytes   = BYTES_W'(nbytes);
        it.header_only = hdr;
        it.pkt_kind    = KIND_W'(kind);
        it.bounce_ok   = bounce;
        it.trim_coin   = coin;
        it.ecn_random  = rnd;
        return it;
    endfunction

    // Random item with a given mix of dequeues, headers and full-size packets
    function automatic item_t rand_item(input int deq_pct, input int hdr_pct,
                                        input int big_pct, input int size_cap);
        item_t it;
        int    r;
        r = $urandom_range(99);
        it = make_item(OP_ARRIVE, TAG_W'($urandom), 1, ($urandom_range(99) < hdr_pct),
                       $urandom_range(3), $urandom_range(1), $urandom_range(1),
                       RND_W'($urandom));
        if (r < deq_pct)
            it.op = OP_DEQUEUE;
        else if (r < deq_pct + 6)
            it.op = OP_TICK;
        else if (r < deq_pct + 8)
            it.op = OP_NONE;
        r = $urandom_range(99);
        if (r < big_pct)
            it.pkt_bytes = BYTES_W'(16383);
        else if (r < big_pct + 5)
            it.pkt_bytes = BYTES_W'(1);
        else
            it.pkt_bytes = BYTES_W'($urandom_range(size_cap, 1));
        r = $urandom_range(9);
        if (r == 0)
            it.ecn_random = '0;
        else if (r == 1)
            it.ecn_random = '1;
        else if (r < 5)
            it.ecn_random = RND_W'($urandom_range(1 << 20));
        return it;
    endfunction

    // Drive one item and hold it until the block takes it
    task automatic send_item(input item_t it);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 83 : (idle_mode == IDLE_BOTH) ? 13 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= it.op;
        in_ch.tag         <= it.tag;
        in_ch.pkt_bytes   <= it.pkt_bytes;
        in_ch.header_only <= it.header_only;
        in_ch.pkt_kind    <= it.pkt_kind;
        in_ch.bounce_ok   <= it.bounce_ok;
        in_ch.trim_coin   <= it.trim_coin;
        in_ch.ecn_random  <= it.ecn_random;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready))
            @(posedge clk);
        predict_queue(it);
        items_sent++;
    endtask

    // Let every outstanding item finish, including ones without a result
    task automatic settle_queue();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input longint unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_BYTES:      sh_max_bytes = val & 24'hFFFFFF;
            CFG_DROP_WHEN_FULL: sh_drop_full = val & 1;
            CFG_USE_PHANTOM:    sh_use_ph    = val & 1;
            CFG_PHANTOM_BYTES:  sh_ph_bytes  = val & 24'hFFFFFF;
            CFG_ECN_LOW_MARK:   sh_ecn_lo    = val & 25'h1FFFFFF;
            CFG_ECN_HIGH_MARK:  sh_ecn_hi    = val & 25'h1FFFFFF;
            CFG_WEIGHT_HIGH:    sh_w_high    = val & 8'hFF;
            default:            sh_w_low     = val & 8'hFF;
        endcase
    endtask

    task automatic apply_cfg(input longint unsigned maxb, input bit drop, input bit ph,
                             input longint unsigned phb, input longint unsigned lo,
                             input longint unsigned hi, input int wh, input int wl);
        settle_queue();
        write_reg(CFG_MAX_BYTES, maxb);
        write_reg(CFG_DROP_WHEN_FULL, drop);
        write_reg(CFG_USE_PHANTOM, ph);
        write_reg(CFG_PHANTOM_BYTES, phb);
        write_reg(CFG_ECN_LOW_MARK, lo);
        write_reg(CFG_ECN_HIGH_MARK, hi);
        write_reg(CFG_WEIGHT_HIGH, wh);
        write_reg(CFG_WEIGHT_LOW, wl);
        // Wait for the registered derived thresholds to follow the writes
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int deq_pct, input int hdr_pct,
                              input int big_pct, input int size_cap);
        item_t it;
        int    done;
        done = 0;
        while (done < count)
        begin
            it = rand_item(deq_pct, hdr_pct, big_pct, size_cap);
            send_item(it);
            if (it.op != OP_NONE)
                done++;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cycle_count    = 0;
        err_count      = 0;
        items_sent     = 0;
        results_seen   = 0;
        idle_mode      = IDLE_NONE;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_ch.valid       = 1'b0;
        in_ch.action      = '0;
        in_ch.tag         = '0;
        in_ch.pkt_bytes   = '0;
        in_ch.header_only = 1'b0;
        in_ch.pkt_kind    = '0;
        in_ch.bounce_ok   = 1'b0;
        in_ch.trim_coin   = 1'b0;
        in_ch.ecn_random  = '0;
        out_ch.ready      = 1'b0;

        sh_max_bytes = 65536;  sh_drop_full = 0; sh_use_ph = 0; sh_ph_bytes = 0;
        sh_ecn_lo = 33554431; sh_ecn_hi = 33554431; sh_w_high = 100; sh_w_low = 1;
        low_hd = 0; low_cnt = 0; high_hd = 0; high_cnt = 0;
        low_bytes = 0; high_bytes = 0; ph_level = 0; rr_cnt = 0;

        // Directed rows; typed expectations only where obvious
        dir_rows.push_back('{make_item(OP_DEQUEUE, 16'h1234, 5, 0, 1, 1, 1, '1), 1'b1,
                             '{EV_EMPTY, 16'd0, 14'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1}});
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'hFFFF, 16383, 0, 0, 1, 0, '0), 1'b1,
                             '{EV_QLOW, 16'hFFFF, 14'd16383, 2'd0, 1'b0, 1'b0, 1'b0,
                               1'b1}});
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0000, 1, 1, 3, 0, 0, '0), 1'b1,
                             '{EV_QHIGH, 16'd0, 14'd1, 2'd3, 1'b0, 1'b0, 1'b0, 1'b1}});
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0002, 16383, 0, 0, 0, 0, '0), 0, '0});
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0003, 16383, 0, 0, 1, 0, '0), 0, '0});
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0004, 16383, 0, 0, 0, 0, '0), 0, '0});
        // Overflow without coin: arrival is trimmed
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0005, 16383, 0, 0, 1, 0, '0), 0, '0});
        // Overflow with coin: newest low entry is evicted
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0006, 16383, 0, 0, 1, 1, '0), 0, '0});
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0007, 1, 0, 2, 0, 1, '0), 0, '0});
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0008, 64, 1, 1, 1, 0, '0), 0, '0});
        dir_rows.push_back('{make_item(OP_ARRIVE, 16'h0009, 64, 1, 2, 0, 1, '0), 0, '0});
        dir_rows.push_back('{make_item(OP_TICK, 16'h000A, 1, 0, 0, 0, 0, '0), 0, '0});
        dir_rows.push_back('{make_item(OP_NONE, 16'h000B, 9, 1, 3, 1, 1, '1), 0, '0});
        for (int k = 0; k < 10; k++)
            dir_rows.push_back('{make_item(OP_DEQUEUE, 16'(k), 1, 0, 0, 0, 0,
                                           (k % 2) ? '1 : '0), 0, '0});

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset configuration
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].it);
            if (dir_rows[i].has_exp)
            begin
                void'(pending_res.pop_back());
                pending_res.push_back(dir_rows[i].exp);
            end
        end

        // Reset settings, no idling
        apply_cfg(65536, 0, 0, 0, 33554431, 33554431, 100, 1);
        run_random(250, 35, 20, 30, 16383);

        // Tiny capacity: high limit reached, bounces and drops
        idle_mode = IDLE_SEND;
        apply_cfg(1, 0, 0, 0, 0, 1, 1, 1);
        run_random(150, 20, 40, 10, 16383);

        // Drop on full with phantom marking
        idle_mode = IDLE_RECV;
        apply_cfg(4000, 1, 1, 20000, 0, 0, 1, 1);
        run_random(250, 35, 15, 10, 3000);

        // Largest capacity, rare dequeues to fill both stores
        idle_mode = IDLE_BOTH;
        apply_cfg(16777215, 0, 0, 16777215, 1000, 50000, 255, 255);
        run_random(300, 8, 60, 5, 4000);

        // Phantom at full scale, low queue favored
        idle_mode = IDLE_NONE;
        apply_cfg(3000, 0, 1, 16777215, 0, 0, 1, 255);
        run_random(300, 40, 20, 20, 2000);

        // Zero phantom capacity and inverted marks
        idle_mode = IDLE_SEND;
        apply_cfg(20000, 0, 0, 0, 33554431, 0, 255, 1);
        run_random(300, 40, 20, 20, 8000);

        // Linear RED ramp on low bytes, mixed idling
        idle_mode = IDLE_BOTH;
        apply_cfg(65536, 0, 0, 1, 5000, 60000, 100, 1);
        run_random(300, 40, 15, 30, 16383);

        settle_queue();
        $display("ran %0d items over 7 configurations, %0d results checked", items_sent,
                 results_seen);
        $display("covered trimming, eviction, bounce, drop, phantom and RED marking");
        if (err_count == 0)
            $display("[trimming_queue_phantom_ecn] OK");
        else
            $display("[trimming_queue_phantom_ecn] ERROR");
        $finish;
    end

endmodule
